FILE: design/alm_pkg.sv
// Shared widths, operation codes, status codes and controller command types.
package alm_pkg;

    // Default sizing of the slot table and of one stored entry.
    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 64;

    // Fixed payload field widths.
    localparam int OPCODE_W = 3;
    localparam int SLOT_W   = 7;
    localparam int ORD_W    = 6;
    localparam int KEY_W    = 32;
    localparam int CNT_W    = 31;
    localparam int STATUS_W = 3;

    // Operation codes.
    localparam logic [OPCODE_W-1:0] OP_INS_AFTER   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_INS_BEFORE  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_PUSH        = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POP         = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_REMOVE      = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_ORD_TO_SLOT = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_SLOT_TO_ORD = 3'd6;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_AFTER  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_BEFORE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    // Datapath commands issued by the controller.
    typedef logic [3:0] t_cmd_code;
    localparam t_cmd_code CMD_NOP       = 4'd0;
    localparam t_cmd_code CMD_CLEAR     = 4'd1;
    localparam t_cmd_code CMD_LOAD      = 4'd2;
    localparam t_cmd_code CMD_READ      = 4'd3;
    localparam t_cmd_code CMD_INS_CAP   = 4'd4;
    localparam t_cmd_code CMD_INS_W1    = 4'd5;
    localparam t_cmd_code CMD_INS_W2    = 4'd6;
    localparam t_cmd_code CMD_REM_CAP   = 4'd7;
    localparam t_cmd_code CMD_REM_W1    = 4'd8;
    localparam t_cmd_code CMD_REM_W2    = 4'd9;
    localparam t_cmd_code CMD_WALK_INIT = 4'd10;
    localparam t_cmd_code CMD_WALK_RD   = 4'd11;
    localparam t_cmd_code CMD_WALK_ADV  = 4'd12;
    localparam t_cmd_code CMD_DATA_RD   = 4'd13;
    localparam t_cmd_code CMD_DATA_CAP  = 4'd14;
    localparam t_cmd_code CMD_FINISH    = 4'd15;

    typedef struct packed {
        t_cmd_code             code;
        logic [STATUS_W-1:0]   status;
    } t_cmd;

    // Status returned by the datapath to the controller.
    typedef struct packed {
        logic                  taken;
        logic                  clr_done;
        logic [OPCODE_W-1:0]   opcode;
        logic                  anchor_ok;
        logic                  full;
        logic                  target_live;
        logic                  walk_done;
        logic                  found;
        logic                  out_busy;
    } t_stat;

endpackage

FILE: design/alm_if.sv
// Request and response channel interfaces with valid/ready handshakes.
interface alm_req_if;
    logic                       valid;
    logic                       ready;
    logic [2:0]                 opcode;
    logic [6:0]                 target_slot;
    logic [5:0]                 target_ordinal;
    logic signed [31:0]         item_key;
    logic [30:0]                item_count;

    modport source (output valid, opcode, target_slot, target_ordinal, item_key, item_count,
                    input ready);
    modport sink   (input valid, opcode, target_slot, target_ordinal, item_key, item_count,
                    output ready);
endinterface

interface alm_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [2:0]                 status;
    logic [6:0]                 result_slot;
    logic [5:0]                 result_ordinal;
    logic signed [31:0]         out_key;
    logic [30:0]                out_count;

    modport source (output valid, status, result_slot, result_ordinal, out_key, out_count,
                    input ready);
    modport sink   (input valid, status, result_slot, result_ordinal, out_key, out_count,
                    output ready);
endinterface

FILE: design/array_linked_list_manager.sv
// Doubly linked list manager over a slot table, with a free list and a per-slot live flag.
// Ordinal lookups walk the list link by link from the head and stop at the end of the list
// when the ordinal lies beyond it; a rejected request goes straight to the result.
// A new request is taken only after the result is loaded into the output register.
// After reset the link table is initialised one slot per cycle, and no request is taken
// until that pass completes.
module array_linked_list_manager #(
    parameter int CAPACITY   = alm_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = alm_pkg::DATA_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    alm_req_if.sink   i_req,
    alm_rsp_if.source o_rsp
);
    import alm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Operation sequencer.
    alm_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_stat (stat),
        .o_cmd  (cmd)
    );

    // Link memories, list registers and result register.
    alm_dp #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (i_req),
        .o_rsp  (o_rsp),
        .i_cmd  (cmd),
        .o_stat (stat)
    );
endmodule

FILE: design/alm_ram.sv
// Generic single write port, single read port RAM with registered read data.
module alm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/alm_ctrl.sv
// Controller state machine that sequences each operation over the datapath.
module alm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  alm_pkg::t_stat i_stat,
    output alm_pkg::t_cmd  o_cmd
);
    import alm_pkg::*;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_CHK   = 4'd3;
    localparam logic [3:0] S_IW1   = 4'd4;
    localparam logic [3:0] S_IW2   = 4'd5;
    localparam logic [3:0] S_RW1   = 4'd6;
    localparam logic [3:0] S_RW2   = 4'd7;
    localparam logic [3:0] S_WINIT = 4'd8;
    localparam logic [3:0] S_WCHK  = 4'd9;
    localparam logic [3:0] S_WADV  = 4'd10;
    localparam logic [3:0] S_DCAP  = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;

    logic [3:0]          r_state, n_state;
    logic [STATUS_W-1:0] r_fst, n_fst;
    t_cmd_code           cmd_code;

    // Next state, command and final status selection.
    always_comb begin
        n_state  = r_state;
        n_fst    = r_fst;
        cmd_code = CMD_NOP;
        unique case (r_state)
            S_CLR: begin
                cmd_code = CMD_CLEAR;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                cmd_code = CMD_LOAD;
                if (i_stat.taken) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                cmd_code = CMD_READ;
                n_state  = S_CHK;
                case (i_stat.opcode) inside
                    OP_ORD_TO_SLOT: n_state = S_WINIT;
                    OP_INS_AFTER, OP_INS_BEFORE, OP_PUSH, OP_POP, OP_REMOVE,
                    OP_SLOT_TO_ORD: n_state = S_CHK;
                    default: begin
                        n_fst   = ST_NOT_FOUND;
                        n_state = S_FIN;
                    end
                endcase
            end
            S_CHK: begin
                case (i_stat.opcode) inside
                    OP_INS_AFTER, OP_INS_BEFORE, OP_PUSH: begin
                        if (!i_stat.anchor_ok) begin
                            n_fst   = (i_stat.opcode == OP_INS_BEFORE) ? ST_NO_BEFORE
                                                                         : ST_NO_AFTER;
                            n_state = S_FIN;
                        end else if (i_stat.full) begin
                            n_fst   = ST_FULL;
                            n_state = S_FIN;
                        end else begin
                            cmd_code = CMD_INS_CAP;
                            n_state  = S_IW1;
                        end
                    end
                    OP_POP, OP_REMOVE: begin
                        if (!i_stat.target_live) begin
                            n_fst   = ST_NOT_FOUND;
                            n_state = S_FIN;
                        end else begin
                            cmd_code = CMD_REM_CAP;
                            n_state  = S_RW1;
                        end
                    end
                    default: begin
                        if (!i_stat.target_live) begin
                            n_fst   = ST_NOT_FOUND;
                            n_state = S_FIN;
                        end else begin
                            cmd_code = CMD_WALK_INIT;
                            n_state  = S_WCHK;
                        end
                    end
                endcase
            end
            S_IW1: begin
                cmd_code = CMD_INS_W1;
                n_state  = S_IW2;
            end
            S_IW2: begin
                cmd_code = CMD_INS_W2;
                n_fst    = ST_OK;
                n_state  = S_FIN;
            end
            S_RW1: begin
                cmd_code = CMD_REM_W1;
                n_state  = S_RW2;
            end
            S_RW2: begin
                cmd_code = CMD_REM_W2;
                n_fst    = ST_OK;
                n_state  = S_FIN;
            end
            S_WINIT: begin
                cmd_code = CMD_WALK_INIT;
                n_state  = S_WCHK;
            end
            S_WCHK: begin
                if (i_stat.walk_done) begin
                    if (i_stat.found) begin
                        cmd_code = CMD_DATA_RD;
                        n_fst    = ST_OK;
                        n_state  = S_DCAP;
                    end else begin
                        n_fst   = ST_NOT_FOUND;
                        n_state = S_FIN;
                    end
                end else begin
                    cmd_code = CMD_WALK_RD;
                    n_state  = S_WADV;
                end
            end
            S_WADV: begin
                cmd_code = CMD_WALK_ADV;
                n_state  = S_WCHK;
            end
            S_DCAP: begin
                cmd_code = CMD_DATA_CAP;
                n_state  = S_FIN;
            end
            S_FIN: begin
                cmd_code = CMD_FINISH;
                if (!i_stat.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and final status registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
        r_fst <= n_fst;
    end

    assign o_cmd.code   = cmd_code;
    assign o_cmd.status = r_fst;

`ifndef SYNTHESIS
    // No request is taken while the link table is being initialised.
    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !i_stat.taken)
        else $error("request taken during table initialisation");

    // A request is only ever taken while the controller is idle.
    a_take_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.taken |-> (r_state == S_IDLE))
        else $error("request taken outside the idle state");

    // The state register only ever holds a defined state.
    a_state_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state <= S_FIN)
        else $error("controller in an undefined state");
`endif
endmodule

FILE: design/alm_dp.sv
// Datapath: link and entry memories, list registers, walk counter and result register.
module alm_dp #(
    parameter int CAPACITY   = alm_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = alm_pkg::DATA_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    alm_req_if.sink       i_req,
    alm_rsp_if.source     o_rsp,
    input  alm_pkg::t_cmd i_cmd,
    output alm_pkg::t_stat o_stat
);
    import alm_pkg::*;

    localparam int DEPTH = CAPACITY + 1;
    localparam int LW    = $clog2(DEPTH);
    localparam int IW    = (LW > ORD_W) ? LW : ORD_W;
    localparam int PLW   = LW + 1;

    // Latched request fields.
    logic [OPCODE_W-1:0]   r_op;
    logic [SLOT_W-1:0]     r_slot;
    logic [ORD_W-1:0]      r_ord;
    logic [DATA_WIDTH-1:0] r_data;

    // List registers and working registers.
    logic [LW-1:0] r_head, r_tail, r_free, r_clr;
    logic [LW-1:0] r_a, r_nx, r_t, r_p, r_n, r_e;
    logic [IW-1:0] r_i;
    logic [DATA_WIDTH-1:0] r_ent;

    // Result register.
    logic                  r_o_valid;
    logic [STATUS_W-1:0]   r_o_status;
    logic [SLOT_W-1:0]     r_o_slot;
    logic [ORD_W-1:0]      r_o_ord;
    logic [KEY_W-1:0]      r_o_key;
    logic [CNT_W-1:0]      r_o_cnt;

    // Memory ports.
    logic                  nx_we, pl_we, en_we;
    logic [LW-1:0]         nx_waddr, pl_waddr, en_waddr;
    logic [LW-1:0]         nx_raddr, pl_raddr, en_raddr;
    logic [LW-1:0]         nx_wdata, nx_rdata;
    logic [PLW-1:0]        pl_wdata, pl_rdata;
    logic [DATA_WIDTH-1:0] en_wdata, en_rdata;

    logic                  slot_in_range, aidx_valid, target_live, zero_anchor, out_busy;
    logic [LW-1:0]         s_idx, aidx;
    logic [63:0]           ent64;

    alm_ram #(.WIDTH(LW), .DEPTH(DEPTH)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_waddr), .i_wdata(nx_wdata),
        .i_raddr(nx_raddr), .o_rdata(nx_rdata)
    );

    // Previous link with the live flag in the top bit.
    alm_ram #(.WIDTH(PLW), .DEPTH(DEPTH)) u_prev (
        .i_clk(i_clk), .i_we(pl_we), .i_waddr(pl_waddr), .i_wdata(pl_wdata),
        .i_raddr(pl_raddr), .o_rdata(pl_rdata)
    );

    alm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_entry (
        .i_clk(i_clk), .i_we(en_we), .i_waddr(en_waddr), .i_wdata(en_wdata),
        .i_raddr(en_raddr), .o_rdata(en_rdata)
    );

    // Target slot decode and anchor checks.
    assign slot_in_range = (r_slot != '0) && (int'(r_slot) <= CAPACITY);
    assign s_idx         = slot_in_range ? LW'(r_slot) : '0;
    assign aidx          = (r_op == OP_PUSH || r_op == OP_POP) ? r_tail : s_idx;
    assign aidx_valid    = (r_op == OP_PUSH || r_op == OP_POP) ? (r_tail != '0)
                                                               : slot_in_range;
    assign target_live   = aidx_valid && pl_rdata[LW];
    assign zero_anchor   = (r_op == OP_PUSH) ? (r_tail == '0) : (r_slot == '0);
    assign out_busy      = r_o_valid && !o_rsp.ready;

    assign o_stat.taken       = i_req.valid && i_req.ready;
    assign o_stat.clr_done    = (r_clr == LW'(CAPACITY));
    assign o_stat.opcode      = r_op;
    assign o_stat.anchor_ok   = (r_op == OP_INS_BEFORE) ? target_live
                              : (zero_anchor ? (r_head == '0) : target_live);
    assign o_stat.full        = (r_free == '0);
    assign o_stat.target_live = target_live;
    assign o_stat.walk_done   = (r_e == '0) ||
                                ((r_op == OP_ORD_TO_SLOT) ? (IW'(r_ord) == r_i)
                                 : ((r_i == IW'(CAPACITY)) || (r_e == r_t)));
    assign o_stat.found       = (r_op == OP_ORD_TO_SLOT) ? (r_e != '0) : (r_e == r_t);
    assign o_stat.out_busy    = out_busy;

    // Memory addresses and write data per command.
    always_comb begin
        nx_we = 1'b0; nx_waddr = '0; nx_wdata = '0; nx_raddr = '0;
        pl_we = 1'b0; pl_waddr = '0; pl_wdata = '0; pl_raddr = '0;
        en_we = 1'b0; en_waddr = '0; en_wdata = '0; en_raddr = '0;
        case (i_cmd.code)
            CMD_CLEAR: begin
                nx_we    = 1'b1;
                nx_waddr = r_clr;
                nx_wdata = (r_clr == '0 || r_clr == LW'(CAPACITY)) ? '0 : r_clr + LW'(1);
                pl_we    = 1'b1;
                pl_waddr = r_clr;
            end
            CMD_READ: begin
                nx_raddr = aidx;
                pl_raddr = aidx;
                en_raddr = aidx;
            end
            CMD_INS_CAP: begin
                nx_raddr = r_free;
            end
            CMD_INS_W1: begin
                nx_we    = 1'b1;
                nx_waddr = r_free;
                nx_wdata = r_nx;
                pl_we    = 1'b1;
                pl_waddr = r_free;
                pl_wdata = {1'b1, r_a};
                en_we    = 1'b1;
                en_waddr = r_free;
                en_wdata = r_data;
            end
            CMD_INS_W2: begin
                nx_we    = (r_a != '0);
                nx_waddr = r_a;
                nx_wdata = r_t;
                pl_we    = (r_nx != '0);
                pl_waddr = r_nx;
                pl_wdata = {1'b1, r_t};
            end
            CMD_REM_W1: begin
                nx_we    = (r_p != '0);
                nx_waddr = r_p;
                nx_wdata = r_n;
                pl_we    = (r_n != '0);
                pl_waddr = r_n;
                pl_wdata = {1'b1, r_p};
            end
            CMD_REM_W2: begin
                nx_we    = 1'b1;
                nx_waddr = r_t;
                nx_wdata = r_free;
                pl_we    = 1'b1;
                pl_waddr = r_t;
            end
            CMD_WALK_RD: begin
                nx_raddr = r_e;
            end
            CMD_DATA_RD: begin
                en_raddr = r_e;
            end
            default: begin
            end
        endcase
    end

    assign ent64 = 64'(r_ent);

    // Control registers: list ends, free head, initialisation counter, result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_free    <= LW'(1);
            r_clr     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_rsp.valid && o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
            case (i_cmd.code)
                CMD_CLEAR: r_clr <= r_clr + LW'(1);
                CMD_INS_W1: r_free <= nx_rdata;
                CMD_INS_W2: begin
                    if (r_a == '0) begin
                        r_head <= r_t;
                    end
                    if (r_a == r_tail) begin
                        r_tail <= r_t;
                    end
                end
                CMD_REM_W1: begin
                    if (r_p == '0) begin
                        r_head <= r_n;
                    end
                    if (r_n == '0) begin
                        r_tail <= r_p;
                    end
                end
                CMD_REM_W2: r_free <= r_t;
                CMD_FINISH: begin
                    if (!out_busy) begin
                        r_o_valid <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.code)
            CMD_LOAD: begin
                if (i_req.valid) begin
                    r_op   <= i_req.opcode;
                    r_slot <= i_req.target_slot;
                    r_ord  <= i_req.target_ordinal;
                    r_data <= DATA_WIDTH'({1'b0, i_req.item_count, i_req.item_key});
                end
            end
            CMD_INS_CAP: begin
                r_a  <= (r_op == OP_INS_BEFORE) ? pl_rdata[LW-1:0] : aidx;
                r_nx <= (r_op == OP_INS_BEFORE) ? aidx
                      : (zero_anchor ? r_head : nx_rdata);
            end
            CMD_INS_W1: r_t <= r_free;
            CMD_REM_CAP: begin
                r_t   <= aidx;
                r_p   <= pl_rdata[LW-1:0];
                r_n   <= nx_rdata;
                r_ent <= en_rdata;
            end
            CMD_WALK_INIT: begin
                r_e <= r_head;
                r_i <= '0;
                r_t <= aidx;
            end
            CMD_WALK_ADV: begin
                r_e <= nx_rdata;
                r_i <= r_i + IW'(1);
            end
            CMD_DATA_CAP: r_ent <= en_rdata;
            CMD_FINISH: begin
                if (!out_busy) begin
                    r_o_status <= i_cmd.status;
                    r_o_slot   <= '0;
                    r_o_ord    <= '0;
                    r_o_key    <= '0;
                    r_o_cnt    <= '0;
                    if (i_cmd.status == ST_OK) begin
                        case (r_op) inside
                            OP_INS_AFTER, OP_INS_BEFORE, OP_PUSH: begin
                                r_o_slot <= SLOT_W'(r_t);
                            end
                            OP_POP, OP_REMOVE: begin
                                r_o_slot <= SLOT_W'(r_t);
                                r_o_key  <= ent64[31:0];
                                r_o_cnt  <= ent64[62:32];
                            end
                            OP_ORD_TO_SLOT: begin
                                r_o_slot <= SLOT_W'(r_e);
                                r_o_ord  <= r_ord;
                                r_o_key  <= ent64[31:0];
                                r_o_cnt  <= ent64[62:32];
                            end
                            default: begin
                                r_o_slot <= SLOT_W'(r_t);
                                r_o_ord  <= r_i[ORD_W-1:0];
                                r_o_key  <= ent64[31:0];
                                r_o_cnt  <= ent64[62:32];
                            end
                        endcase
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign i_req.ready          = (i_cmd.code == CMD_LOAD);
    assign o_rsp.valid          = r_o_valid;
    assign o_rsp.status         = r_o_status;
    assign o_rsp.result_slot    = r_o_slot;
    assign o_rsp.result_ordinal = r_o_ord;
    assign o_rsp.out_key        = $signed(r_o_key);
    assign o_rsp.out_count      = r_o_cnt;

`ifndef SYNTHESIS
    // An empty list has neither head nor tail; a non-empty one has both.
    a_ends_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == '0) == (r_tail == '0))
        else $error("head and tail disagree on list emptiness");

    // A slot is only taken from a non-empty free list.
    a_alloc_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.code == CMD_INS_W1) |-> (r_free != '0))
        else $error("allocation from an empty free list");

    // Only a real slot is returned to the free list.
    a_release_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.code == CMD_REM_W2) |-> (r_t != '0))
        else $error("sentinel returned to the free list");
`endif
endmodule
